// ----- design/es_kernel_evaluator_defines.svh -----
// Assertion macros used by the kernel evaluator top module.
// Depends on nothing; included only by es_kernel_evaluator.sv, which checks its own logic.
`ifndef ES_KERNEL_EVALUATOR_DEFINES_SVH
`define ES_KERNEL_EVALUATOR_DEFINES_SVH

// Property that must never hold while out of reset.
`define ESKE_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Same-cycle implication while out of reset.
`define ESKE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/eske_pkg.sv -----
// Types and constants of the kernel evaluator.
// Depends on nothing; imported by every module of the block.
package eske_pkg;

   typedef struct packed {
      logic signed [31:0] arg_x;
      logic               vector_end;
   } eske_req_type;

   typedef struct packed {
      logic [8:0]  value_exponent;
      logic [31:0] value_mantissa;
      logic        out_of_support;
      logic        vector_end_out;
   } eske_rsp_type;

   // Side information that rides along with every word.
   typedef struct packed {
      logic vector_end;
      logic oos;
   } eske_tag_type;

   typedef logic [15:0][31:0] eske_rom_type;

   localparam logic [63:0] ONE_Q48   = 64'h0001_0000_0000_0000;
   localparam logic [31:0] LOG2E_Q31 = 32'hB8AA_3B29;
   localparam logic [31:0] LN2_C1    = 32'd2977044472;
   localparam logic [31:0] LN2_C2    = 32'd1031764991;
   localparam logic [31:0] LN2_C3    = 32'd238388332;
   localparam logic [31:0] LN2_C4    = 32'd41309549;
   localparam logic [31:0] MANT_ONE  = 32'h8000_0000;

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] b;
      n   = n_in;
      res = '0;
      b   = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Entry i is 2^(i/16) in Q.31, built from a chain of truncated roots.
   function automatic eske_rom_type build_rom();
      logic [63:0]  root [4];
      logic [63:0]  v;
      eske_rom_type rom;
      root[3] = isqrt64(64'h8000_0000_0000_0000);
      root[2] = isqrt64(root[3] << 31);
      root[1] = isqrt64(root[2] << 31);
      root[0] = isqrt64(root[1] << 31);
      for (int idx = 0; idx < 16; idx++) begin
         v = 64'h8000_0000;
         for (int j = 0; j < 4; j++) begin
            if (idx[j]) begin
               v = (v * root[j]) >> 31;
            end
         end
         rom[idx] = v[31:0];
      end
      return rom;
   endfunction

   localparam eske_rom_type EXP2_ROM = build_rom();

endpackage

// ----- design/eske_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on eske_pkg for the tag type.
module eske_sqrt
   import eske_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  logic [63:0]  in_rad,
   input  logic         in_full,
   input  eske_tag_type in_tag,
   output logic         out_valid,
   output logic [31:0]  out_root,
   output logic         out_full,
   output eske_tag_type out_tag
);

   localparam int STEPS = 32;

   logic               valid_ff [STEPS];
   logic [33:0]        rem_ff   [STEPS];
   logic [31:0]        root_ff  [STEPS];
   logic [63:0]        rad_ff   [STEPS];
   logic               full_ff  [STEPS];
   eske_tag_type       tag_ff   [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic         v_cur;
      logic [33:0]  r_cur;
      logic [31:0]  q_cur;
      logic [63:0]  rad_cur;
      logic         full_cur;
      eske_tag_type tag_cur;
      logic [35:0]  r_shift;
      logic [35:0]  trial;
      logic         ge;
      logic [33:0]  rem_in;
      logic [31:0]  root_in;

      if (s == 0) begin : g_first
         assign v_cur    = in_valid;
         assign r_cur    = '0;
         assign q_cur    = '0;
         assign rad_cur  = in_rad;
         assign full_cur = in_full;
         assign tag_cur  = in_tag;
      end else begin : g_next
         assign v_cur    = valid_ff[s-1];
         assign r_cur    = rem_ff[s-1];
         assign q_cur    = root_ff[s-1];
         assign rad_cur  = rad_ff[s-1];
         assign full_cur = full_ff[s-1];
         assign tag_cur  = tag_ff[s-1];
      end

      always_comb begin
         r_shift = {r_cur, rad_cur[63:62]};
         trial   = {2'b00, q_cur, 2'b01};
         ge      = (r_shift >= trial);
         rem_in  = ge ? 34'(r_shift - trial) : r_shift[33:0];
         root_in = {q_cur[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= v_cur;
         end
         if (adv) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= {rad_cur[61:0], 2'b00};
            full_ff[s] <= full_cur;
            tag_ff[s]  <= tag_cur;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_full  = full_ff[STEPS-1];
   assign out_tag   = tag_ff[STEPS-1];

endmodule

// ----- design/eske_exp2.sv -----
// Scaling by beta and log2(e), then base-2 exponential by table and polynomial.
// Depends on eske_pkg for constants, the table and the word types.
module eske_exp2
   import eske_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic [31:0]  beta,
   input  logic         in_valid,
   input  logic [31:0]  in_root,
   input  logic         in_full,
   input  eske_tag_type in_tag,
   output logic         out_valid,
   output eske_rsp_type out_rsp
);

   localparam int STAGES = 8;

   logic         valid_ff [STAGES];
   eske_tag_type tag_ff   [STAGES];
   logic [8:0]   k_ff     [1:6];
   logic [3:0]   idx_ff   [1:4];
   logic [27:0]  r_ff     [1:4];
   logic [31:0]  y_ff;
   logic [31:0]  p3_ff;
   logic [31:0]  p2_ff;
   logic [31:0]  p1_ff;
   logic [32:0]  poly_ff;
   logic [31:0]  rom_ff;
   logic [32:0]  mraw_ff;
   eske_rsp_type rsp_ff;

   logic [63:0]  prod_y;
   logic [63:0]  prod_z;
   logic [63:0]  prod_3;
   logic [63:0]  prod_2;
   logic [63:0]  prod_1;
   logic [63:0]  prod_0;
   logic [63:0]  prod_m;
   eske_rsp_type rsp_in;

   always_comb begin
      prod_y = beta * in_root;
      prod_z = y_ff * LOG2E_Q31;
      prod_3 = LN2_C4 * {4'b0000, r_ff[1]};
      prod_2 = p3_ff * {4'b0000, r_ff[2]};
      prod_1 = p2_ff * {4'b0000, r_ff[3]};
      prod_0 = p1_ff * {4'b0000, r_ff[4]};
      prod_m = rom_ff * poly_ff[32:1];

      rsp_in.vector_end_out = tag_ff[6].vector_end;
      rsp_in.out_of_support = tag_ff[6].oos;
      if (tag_ff[6].oos) begin
         rsp_in.value_exponent = '0;
         rsp_in.value_mantissa = '0;
      end else begin
         rsp_in.value_exponent = k_ff[6];
         if (mraw_ff[32]) begin
            rsp_in.value_mantissa = '1;
         end else if (mraw_ff[31:0] < MANT_ONE) begin
            rsp_in.value_mantissa = MANT_ONE;
         end else begin
            rsp_in.value_mantissa = mraw_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         // A radicand of exactly one gives a root of one, so y is beta itself.
         y_ff      <= in_full ? beta : prod_y[63:32];
         k_ff[1]   <= prod_z[63:55];
         idx_ff[1] <= prod_z[54:51];
         r_ff[1]   <= prod_z[50:23];
         for (int s = 2; s <= 6; s++) begin
            k_ff[s] <= k_ff[s-1];
         end
         for (int s = 2; s <= 4; s++) begin
            idx_ff[s] <= idx_ff[s-1];
            r_ff[s]   <= r_ff[s-1];
         end
         p3_ff   <= LN2_C3 + prod_3[63:32];
         p2_ff   <= LN2_C2 + prod_2[63:32];
         p1_ff   <= LN2_C1 + prod_1[63:32];
         poly_ff <= {1'b1, prod_0[63:32]};
         rom_ff  <= EXP2_ROM[idx_ff[4]];
         mraw_ff <= prod_m[63:31];
         rsp_ff  <= rsp_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_rsp   = rsp_ff;

endmodule

// ----- design/es_kernel_evaluator.sv -----
// Kernel evaluator exp(beta*sqrt(1 - c*x*x)): x*x, times c, 32 root stages, 8 exp stages.
// An accepted word passes the square, scale, root and exp registers in turn; one word enters per cycle unless stalled.
// Every stage register moves together, so throughput is one word per cycle while rsp_ready holds.
// Synchronous reset empties the pipeline and loads beta and c with their defaults.
// Depends on eske_pkg, eske_sqrt, eske_exp2 and the assertion macro header.
`include "es_kernel_evaluator_defines.svh"
module es_kernel_evaluator
   import eske_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  eske_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output eske_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam logic        CSR_BETA   = 1'b0;
   localparam logic        CSR_SCALE  = 1'b1;
   localparam logic [31:0] BETA_RST   = 32'd463051162;
   localparam logic [31:0] SCALE_RST  = 32'd7456540;

   logic [31:0]  beta_ff;
   logic [31:0]  scale_ff;
   logic         csr_wr;

   logic         adv;
   logic         v1_ff, v2_ff, v3_ff;
   logic         ve1_ff, ve2_ff;
   eske_tag_type tag3_ff;
   logic [63:0]  xsq_ff;
   logic [63:0]  lo_ff;
   logic [63:0]  hi_ff;
   logic [63:0]  rad_ff;
   logic         full_ff;

   logic [31:0]  ax;
   logic [63:0]  xsq_in;
   logic [63:0]  lo_in;
   logic [63:0]  hi_in;
   logic [63:0]  m;
   logic         nz;
   logic         oos;
   logic [48:0]  d48;

   logic         sq_valid;
   logic [31:0]  sq_root;
   logic         sq_full;
   eske_tag_type sq_tag;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff  <= BETA_RST;
         scale_ff <= SCALE_RST;
      end else if (csr_wr) begin
         case (paddr[2])
            CSR_BETA:  beta_ff  <= pwdata;
            CSR_SCALE: scale_ff <= pwdata;
            default:   beta_ff  <= beta_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_BETA:  prdata = beta_ff;
         CSR_SCALE: prdata = scale_ff;
         default:   prdata = '0;
      endcase
   end

   // The whole pipeline stalls only while the result word waits.
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   always_comb begin
      ax     = req_data.arg_x[31] ? 32'(~req_data.arg_x + 32'sd1) : req_data.arg_x;
      xsq_in = ax * ax;
      lo_in  = scale_ff * xsq_ff[31:0];
      hi_in  = scale_ff * xsq_ff[63:32];
      m      = hi_ff + {32'h0, lo_ff[63:32]};
      nz     = |lo_ff[31:0];
      oos    = (m > ONE_Q48) || ((m == ONE_Q48) && nz);
      d48    = 49'(ONE_Q48) - m[48:0] - {48'h0, nz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xsq_ff             <= xsq_in;
         ve1_ff             <= req_data.vector_end;
         lo_ff              <= lo_in;
         hi_ff              <= hi_in;
         ve2_ff             <= ve1_ff;
         tag3_ff.vector_end <= ve2_ff;
         tag3_ff.oos        <= oos;
         // When 1 - c*x*x is exactly one the radicand overflows; flag it instead.
         full_ff            <= (m == 64'h0) && !nz;
         rad_ff             <= {d48[47:0], 16'h0000};
      end
   end

   eske_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .in_rad    (rad_ff),
      .in_full   (full_ff),
      .in_tag    (tag3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_full  (sq_full),
      .out_tag   (sq_tag)
   );

   eske_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .beta      (beta_ff),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_full   (sq_full),
      .in_tag    (sq_tag),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   `ESKE_ASSERT_IMPLY(a_oos_zero, clock, reset,
      rsp_valid && rsp_data.out_of_support,
      (rsp_data.value_mantissa == 32'h0) && (rsp_data.value_exponent == 9'h0),
      "out-of-support word carries a value")
   `ESKE_ASSERT_IMPLY(a_mant_norm, clock, reset,
      rsp_valid && !rsp_data.out_of_support, rsp_data.value_mantissa[31],
      "mantissa below one")
   `ESKE_ASSERT_IMPLY(a_stall_cause, clock, reset,
      !req_ready, rsp_valid && !rsp_ready,
      "pipeline stalled without a waiting result word")
   `ESKE_ASSERT_NEVER(a_edge_oos, clock, reset,
      v3_ff && full_ff && tag3_ff.oos,
      "zero product flagged out of support")

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the kernel evaluator: random and directed arguments
// through valid/ready with idling, results checked against an inline predictor.
// Depends on eske_pkg and es_kernel_evaluator.
`timescale 1ns / 100ps
module testbench;
   import eske_pkg::*;

   localparam logic [2:0] ADDR_BETA  = 3'd0;
   localparam logic [2:0] ADDR_SCALE = 3'd4;
   localparam int         DRAIN_CYCLES = 60;
   localparam int         CYCLE_LIMIT  = 600000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   eske_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   eske_rsp_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   es_kernel_evaluator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0]  beta_now  = 32'd463051162;
   logic [31:0]  scale_now = 32'd7456540;
   eske_req_type args_pending [$];
   eske_rsp_type kernel_values_due [$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           long_hold_request = 1'b0;
   bit           req_ready_seen = 1'b0;

   // Integer square root by testing each result bit from the top.
   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if (cand * cand <= n) begin
            res = cand;
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] exp2_entry(input logic [3:0] idx);
      logic [63:0] r [4];
      logic [63:0] v;
      r[3] = root_floor(64'h8000_0000_0000_0000);
      r[2] = root_floor(r[3] << 31);
      r[1] = root_floor(r[2] << 31);
      r[0] = root_floor(r[1] << 31);
      v = 64'h8000_0000;
      for (int j = 0; j < 4; j++) begin
         if (idx[j]) begin
            v = (v * r[j]) >> 31;
         end
      end
      return v[31:0];
   endfunction

   function automatic eske_rsp_type eval_kernel(input eske_req_type a);
      eske_rsp_type o;
      logic [63:0] mag, sq, lo, hi, m, rem, d48, q, y24, z32, k, f, r, p, poly, mant;
      o = '0;
      o.vector_end_out = a.vector_end;
      mag = a.arg_x[31] ? (64'd1 << 32) - {32'd0, a.arg_x} : {32'd0, a.arg_x};
      sq  = mag * mag;
      lo  = {32'd0, scale_now} * {32'd0, sq[31:0]};
      hi  = {32'd0, scale_now} * {32'd0, sq[63:32]};
      m   = hi + (lo >> 32);
      rem = {32'd0, lo[31:0]};
      if (m > ONE_Q48 || (m == ONE_Q48 && rem != 0)) begin
         o.out_of_support = 1'b1;
         return o;
      end
      d48 = ONE_Q48 - m - ((rem != 0) ? 64'd1 : 64'd0);
      q = (d48 == ONE_Q48) ? (64'd1 << 32) : root_floor(d48 << 16);
      y24 = ({32'd0, beta_now} * q) >> 32;
      z32 = (y24 * 64'hB8AA_3B29) >> 23;
      k = z32 >> 32;
      f = {32'd0, z32[31:0]};
      r = {36'd0, f[27:0]};
      p = 64'd41309549;
      p = 64'd238388332 + ((p * r) >> 32);
      p = 64'd1031764991 + ((p * r) >> 32);
      p = 64'd2977044472 + ((p * r) >> 32);
      poly = (64'd1 << 32) + ((p * r) >> 32);
      mant = ({32'd0, exp2_entry(f[31:28])} * (poly >> 1)) >> 31;
      if (mant > 64'hFFFF_FFFF) mant = 64'hFFFF_FFFF;
      if (mant < 64'h8000_0000) mant = 64'h8000_0000;
      o.value_exponent = (k > 511) ? 9'd511 : k[8:0];
      o.value_mantissa = mant[31:0];
      return o;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int gap_left = 0;
   int burst_left = 0;
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_ready_seen)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (args_pending.size() > 0) begin
            req_data <= args_pending.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off on request.
   int stall_left = 0;
   int stall_mode = 0;
   always @(negedge clock) begin
      if (long_hold_request && stall_left == 0 && rsp_ready) begin
         long_hold_request <= 1'b0;
         stall_left <= 300;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= (cycle_count % 5 != 0);
         endcase
      end
   end

   // Monitor: acceptance on the input predicts, acceptance on the output checks.
   always @(posedge clock) begin
      eske_rsp_type want;
      req_ready_seen <= req_valid && req_ready;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) begin
            kernel_values_due.push_back(eval_kernel(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (kernel_values_due.size() == 0) begin
               $error("unexpected word: exponent %0d mantissa %h",
                      rsp_data.value_exponent, rsp_data.value_mantissa);
               error_count++;
            end else begin
               want = kernel_values_due.pop_front();
               if (rsp_data.value_exponent !== want.value_exponent) begin
                  $error("value_exponent: expected %0d, actual %0d",
                         want.value_exponent, rsp_data.value_exponent);
                  error_count++;
               end
               if (rsp_data.value_mantissa !== want.value_mantissa) begin
                  $error("value_mantissa: expected %h, actual %h",
                         want.value_mantissa, rsp_data.value_mantissa);
                  error_count++;
               end
               if (rsp_data.out_of_support !== want.out_of_support) begin
                  $error("out_of_support: expected %0d, actual %0d",
                         want.out_of_support, rsp_data.out_of_support);
                  error_count++;
               end
               if (rsp_data.vector_end_out !== want.vector_end_out) begin
                  $error("vector_end_out: expected %0d, actual %0d",
                         want.vector_end_out, rsp_data.vector_end_out);
                  error_count++;
               end
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_BETA) beta_now = value;
      else if (addr == ADDR_SCALE) scale_now = value;
   endtask

   task automatic settle();
      while (args_pending.size() > 0 || req_valid || kernel_values_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_arg(input logic [31:0] x, input logic vend);
      eske_req_type a;
      a.arg_x = x;
      a.vector_end = vend;
      args_pending.push_back(a);
   endtask

   // Random arguments: mostly scaled inside the support, some full range.
   task automatic queue_random(input int count);
      logic signed [31:0] x;
      for (int i = 0; i < count; i++) begin
         x = $urandom;
         x = x >>> $urandom_range(0, 31);
         queue_arg(x, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes, zero and x = +-1.5 inside the support at default settings.
      queue_arg(32'h0000_0000, 1'b0);
      queue_arg(32'h7FFF_FFFF, 1'b1);
      queue_arg(32'h8000_0000, 1'b0);
      queue_arg(32'hFFFF_FFFF, 1'b1);
      queue_arg(32'h0000_0001, 1'b0);
      queue_arg(32'h0600_0000, 1'b0);
      queue_arg(32'hFA00_0000, 1'b1);
      queue_random(150);
      long_hold_request = 1'b1;
      settle();
      // With c = 1.0 the edge x = +-1.0 gives exactly one.
      csr_write(ADDR_SCALE, 32'h1000_0000);
      queue_arg(32'h0400_0000, 1'b0);
      queue_arg(32'hFC00_0000, 1'b1);
      queue_arg(32'h0400_0001, 1'b0);
      queue_arg(32'h03FF_FFFF, 1'b0);
      queue_random(150);
      settle();
      csr_write(ADDR_BETA, 32'hFFFF_FFFF);
      queue_arg(32'h0000_0000, 1'b0);
      queue_random(150);
      settle();
      csr_write(ADDR_BETA, 32'h0000_0000);
      csr_write(ADDR_SCALE, 32'hFFFF_FFFF);
      queue_arg(32'h0000_0000, 1'b1);
      queue_arg(32'h7FFF_FFFF, 1'b0);
      queue_random(150);
      settle();
      csr_write(ADDR_SCALE, 32'h0000_0000);
      csr_write(ADDR_BETA, 32'h8000_0000);
      queue_arg(32'h8000_0000, 1'b0);
      queue_random(150);
      settle();
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(ADDR_BETA, $urandom);
         csr_write(ADDR_SCALE, $urandom >> $urandom_range(0, 12));
         if (ph == 2) long_hold_request = 1'b1;
         queue_random(130);
         settle();
      end
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
